>>> hdl/oai_pkg.sv
// shared types and constants for the ordered array block
`default_nettype none

package oai_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int IN_W     = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;
  localparam int OUT_W    = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND       = 3'd0,
    MODE_INSERT       = 3'd1,
    MODE_REMOVE_IDX   = 3'd2,
    MODE_REMOVE_FIRST = 3'd3,
    MODE_REMOVE_ALL   = 3'd4,
    MODE_READ         = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  // what every cell of the row does each cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

endpackage

`default_nettype wire

>>> hdl/oai_cell.sv
// one storage cell of the element row
`default_nettype none

module oai_cell #(
  parameter int WORD_BITS = oai_pkg::WORD_BITS_DEF,
  parameter int IDX_W     = 4,
  parameter int INDEX     = 0
) (
  input  wire logic                 clk,
  input  wire oai_pkg::cell_op_t    op,
  input  wire logic [IDX_W-1:0]     idx,
  input  wire logic [WORD_BITS-1:0] key,
  input  wire logic [WORD_BITS-1:0] left_data,
  input  wire logic [WORD_BITS-1:0] right_data,
  output logic      [WORD_BITS-1:0] data,
  output logic                      match
);
  import oai_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        // cells above the slot take their lower neighbor
        if (idx == MY_IDX) begin
          data_nxt = key;
        end else if (idx < MY_IDX) begin
          data_nxt = left_data;
        end
      end
      CELL_REMOVE: begin
        if (idx <= MY_IDX) begin
          data_nxt = right_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule

`default_nettype wire

>>> hdl/oai_row.sv
// row of cells with neighbor links, token match and element read
`default_nettype none

module oai_row #(
  parameter int DEPTH     = oai_pkg::DEPTH_DEF,
  parameter int WORD_BITS = oai_pkg::WORD_BITS_DEF,
  parameter int IDX_W     = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire oai_pkg::cell_op_t    op,
  input  wire logic [IDX_W-1:0]     idx,
  input  wire logic [WORD_BITS-1:0] key,
  output logic      [WORD_BITS-1:0] rd_data,
  output logic                      tok_match
);
  import oai_pkg::*;

  logic [WORD_BITS-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]     match_vec;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_d;
    logic [WORD_BITS-1:0] right_d;

    // the bottom cell never shifts up and the top cell has nothing above
    if (g == 0) begin : g_bot
      assign left_d = key;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    oai_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX_W     (IDX_W),
      .INDEX     (g)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .idx        (idx),
      .key        (key),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .match      (match_vec[g])
    );
  end

  assign rd_data   = cell_data[idx];
  assign tok_match = match_vec[idx];

endmodule

`default_nettype wire

>>> hdl/ordered_array_insert_remove.sv
// ordered array of words with insert, remove, search-remove and read requests
//
// in_* carries one request: mode, position and word; out_* returns one
// result per request: status, element count afterwards and the read word.
// Elements sit in a row of cells; each cell can load its lower or upper
// neighbor, so an insert or remove-at-index moves the whole tail at
// once. Append, insert, remove at index and read finish in the accept
// cycle, with the result registered for the next cycle. Remove-first and
// remove-all walk a token from element 0 up to the count, one element per
// cycle while no hit is found. Remove-first stops at the first hit. A hit
// under remove-all removes the element and keeps the token in place. One
// request is in flight at a time. in_tready drops while a search runs and
// while a result waits in the output register with out_tready low; a
// stalled receiver therefore holds the block without losing anything.
// Reset empties the array (count zero) and drops out_tvalid.
`default_nettype none

module ordered_array_insert_remove #(
  parameter int DEPTH     = oai_pkg::DEPTH_DEF,
  parameter int WORD_BITS = oai_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // mode[2:0], position[7:3], word[39:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // status[1:0], length[6:2], read_word[38:7], zero
);
  import oai_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  typedef enum logic [0:0] {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic                found_r, found_nxt;
  logic                all_r, all_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic [OUT_W-1:0]    out_word_r, out_word_nxt;

  mode_t                in_mode;
  logic [POS_W-1:0]     in_pos;
  logic [IN_W-1:0]      in_word;
  logic [WORD_BITS-1:0] in_key;
  logic [IDX_W-1:0]     pos_idx;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic                 in_acc;

  cell_op_t             cell_op;
  logic [IDX_W-1:0]     cell_idx;
  logic [WORD_BITS-1:0] cell_key;
  logic [WORD_BITS-1:0] rd_data;
  logic                 tok_match;

  assign in_mode = mode_t'(in_tdata[2:0]);
  assign in_pos  = in_tdata[7:3];
  assign in_word = in_tdata[39:8];
  // narrower words keep the low bits, wider ones are sign extended
  assign in_key  = WORD_BITS'($signed(in_word));
  assign pos_idx = IDX_W'(in_pos);
  assign pos_ext = CMP_W'(in_pos);
  assign cnt_ext = CMP_W'(count_r);

  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  oai_row #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .IDX_W     (IDX_W)
  ) u_row (
    .clk       (clk),
    .op        (cell_op),
    .idx       (cell_idx),
    .key       (cell_key),
    .rd_data   (rd_data),
    .tok_match (tok_match)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    found_nxt      = found_r;
    all_nxt        = all_r;
    key_nxt        = key_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    out_word_nxt   = out_word_r;
    cell_op        = CELL_HOLD;
    cell_idx       = pos_idx;
    cell_key       = in_key;

    unique case (state_r)
      S_IDLE: begin
        if (in_mode == MODE_APPEND) begin
          cell_idx = count_r[IDX_W-1:0];
        end
        if (in_acc) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = STAT_OK;
          out_word_nxt   = '0;
          case (in_mode)
            MODE_APPEND: begin
              if (count_r == FULL_CNT) begin
                out_status_nxt = STAT_FULL;
              end else begin
                cell_op   = CELL_INSERT;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_INSERT: begin
              if (pos_ext > cnt_ext) begin
                out_status_nxt = STAT_RANGE;
              end else if (count_r == FULL_CNT) begin
                out_status_nxt = STAT_FULL;
              end else begin
                cell_op   = CELL_INSERT;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_REMOVE_IDX: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                cell_op   = CELL_REMOVE;
                count_nxt = count_r - 1'b1;
              end
            end
            MODE_REMOVE_FIRST, MODE_REMOVE_ALL: begin
              out_tvalid_nxt = 1'b0;
              state_nxt      = S_SCAN;
              scan_idx_nxt   = '0;
              found_nxt      = 1'b0;
              all_nxt        = (in_mode == MODE_REMOVE_ALL);
              key_nxt        = in_key;
            end
            MODE_READ: begin
              if (pos_ext >= cnt_ext) begin
                out_status_nxt = STAT_RANGE;
              end else begin
                out_word_nxt = OUT_W'(rd_data);
              end
            end
            default: begin
            end
          endcase
          out_len_nxt = LEN_W'(count_nxt);
        end
      end
      S_SCAN: begin
        cell_key = key_r;
        cell_idx = scan_idx_r[IDX_W-1:0];
        priority if (scan_idx_r == count_r) begin
          state_nxt      = S_IDLE;
          out_tvalid_nxt = 1'b1;
          out_status_nxt = found_r ? STAT_OK : STAT_MISSING;
          out_len_nxt    = LEN_W'(count_r);
          out_word_nxt   = '0;
        end else if (tok_match) begin
          // the next element drops into the token slot, so the token stays
          cell_op   = CELL_REMOVE;
          count_nxt = count_r - 1'b1;
          found_nxt = 1'b1;
          if (!all_r) begin
            state_nxt      = S_IDLE;
            out_tvalid_nxt = 1'b1;
            out_status_nxt = STAT_OK;
            out_len_nxt    = LEN_W'(count_nxt);
            out_word_nxt   = '0;
          end
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    scan_idx_r   <= scan_idx_nxt;
    found_r      <= found_nxt;
    all_r        <= all_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_word_r, out_len_r, out_status_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("element count above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_idx_r <= count_r))
    else $error("search token past element count");

  a_scan_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (count_r <= $past(count_r)))
    else $error("element count grew during search");

  a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_mode == MODE_APPEND) && (count_r == FULL_CNT))
      |=> (out_tvalid_r && (out_status_r == STAT_FULL) && (count_r == FULL_CNT)))
    else $error("append to full array not rejected");

endmodule

`default_nettype wire

>>> tb/sv/tb_ordered_array_insert_remove.sv
// self-checking bench for the ordered array block: directed table, then random requests
module tb_ordered_array_insert_remove;
  import oai_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1910;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 4;

  // mode codes the block leaves unused
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam logic [31:0] EXTREME_WORDS [4] = '{32'h0000_0000, 32'h8000_0000,
                                                32'h7fff_ffff, 32'hffff_ffff};

  typedef struct packed {
    status_t     status;
    logic [4:0]  length;
    logic [31:0] read_word;
  } array_reply_t;

  typedef struct packed {
    logic [2:0]   mode;
    logic [4:0]   position;
    logic [31:0]  word;
    logic [4:0]   reps;
    logic         given;
    array_reply_t reply;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [25] = '{
    '{MODE_READ,         5'd0,  32'h0000_0000, 5'd1,  1'b1, '{STAT_RANGE,   5'd0,  32'd0}},
    '{MODE_REMOVE_IDX,   5'd0,  32'h0000_0000, 5'd1,  1'b1, '{STAT_RANGE,   5'd0,  32'd0}},
    '{MODE_REMOVE_FIRST, 5'd0,  32'h0000_0000, 5'd1,  1'b1, '{STAT_MISSING, 5'd0,  32'd0}},
    '{MODE_REMOVE_ALL,   5'd0,  32'hffff_ffff, 5'd1,  1'b1, '{STAT_MISSING, 5'd0,  32'd0}},
    '{MODE_SPARE_A,      5'd31, 32'hffff_ffff, 5'd1,  1'b1, '{STAT_OK,      5'd0,  32'd0}},
    '{MODE_SPARE_B,      5'd0,  32'h0000_0000, 5'd1,  1'b1, '{STAT_OK,      5'd0,  32'd0}},
    '{MODE_APPEND,       5'd0,  32'h8000_0000, 5'd1,  1'b1, '{STAT_OK,      5'd1,  32'd0}},
    '{MODE_APPEND,       5'd31, 32'h7fff_ffff, 5'd1,  1'b1, '{STAT_OK,      5'd2,  32'd0}},
    '{MODE_INSERT,       5'd3,  32'h1234_5678, 5'd1,  1'b1, '{STAT_RANGE,   5'd2,  32'd0}},
    '{MODE_INSERT,       5'd2,  32'hffff_ffff, 5'd1,  1'b0, '0},
    '{MODE_INSERT,       5'd0,  32'h0000_0000, 5'd1,  1'b0, '0},
    '{MODE_READ,         5'd0,  32'h0000_0000, 5'd1,  1'b1, '{STAT_OK,      5'd4,  32'd0}},
    '{MODE_READ,         5'd3,  32'h0000_0000, 5'd1,  1'b0, '0},
    '{MODE_REMOVE_IDX,   5'd1,  32'h0000_0000, 5'd1,  1'b0, '0},
    '{MODE_APPEND,       5'd0,  32'h5a5a_5a5a, 5'd13, 1'b0, '0},
    '{MODE_APPEND,       5'd0,  32'ha5a5_a5a5, 5'd1,  1'b1, '{STAT_FULL,    5'd16, 32'd0}},
    '{MODE_INSERT,       5'd17, 32'ha5a5_a5a5, 5'd1,  1'b1, '{STAT_RANGE,   5'd16, 32'd0}},
    '{MODE_INSERT,       5'd16, 32'ha5a5_a5a5, 5'd1,  1'b1, '{STAT_FULL,    5'd16, 32'd0}},
    '{MODE_INSERT,       5'd0,  32'ha5a5_a5a5, 5'd1,  1'b1, '{STAT_FULL,    5'd16, 32'd0}},
    '{MODE_READ,         5'd31, 32'h0000_0000, 5'd1,  1'b1, '{STAT_RANGE,   5'd16, 32'd0}},
    '{MODE_READ,         5'd15, 32'h0000_0000, 5'd1,  1'b0, '0},
    '{MODE_REMOVE_FIRST, 5'd0,  32'h5a5a_5a5a, 5'd1,  1'b0, '0},
    '{MODE_REMOVE_ALL,   5'd0,  32'h5a5a_5a5a, 5'd1,  1'b0, '0},
    '{MODE_REMOVE_FIRST, 5'd0,  32'h1234_5678, 5'd1,  1'b0, '0},
    '{MODE_REMOVE_IDX,   5'd2,  32'h0000_0000, 5'd1,  1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // mode[2:0], position[7:3], word[39:8]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // status[1:0], length[6:2], read_word[38:7], zero

  logic [31:0]  shadow_mem [DEPTH];
  int           shadow_len = 0;
  array_reply_t replies_due [$];
  array_reply_t seen_due;
  int           mismatches = 0;
  int           burst_left = 0;
  int           quiet_cycles = 0;
  int           pattern_left = 0;
  logic [15:0]  ready_pattern = 16'hffff;

  ordered_array_insert_remove dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic drop_shadow_entry(input int at);
    int j;
    for (j = at; j + 1 < shadow_len; j++)
      shadow_mem[j] = shadow_mem[j + 1];
    shadow_len--;
  endtask

  // applies one request to the shadow array and returns the reply it should give
  task automatic apply_to_shadow(input logic [2:0] m, input logic [4:0] p,
                                 input logic [31:0] w, output array_reply_t r);
    int i;
    int kept;
    r.status = STAT_OK;
    r.read_word = '0;
    case (m)
      MODE_APPEND: begin
        if (shadow_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          shadow_mem[shadow_len] = w;
          shadow_len++;
        end
      end
      MODE_INSERT: begin
        // position is checked before fullness
        if (p > shadow_len) begin
          r.status = STAT_RANGE;
        end else if (shadow_len >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (i = shadow_len; i > p; i--)
            shadow_mem[i] = shadow_mem[i - 1];
          shadow_mem[p] = w;
          shadow_len++;
        end
      end
      MODE_REMOVE_IDX: begin
        if (p >= shadow_len) r.status = STAT_RANGE;
        else drop_shadow_entry(p);
      end
      MODE_REMOVE_FIRST: begin
        r.status = STAT_MISSING;
        for (i = 0; i < shadow_len && r.status == STAT_MISSING; i++)
          if (shadow_mem[i] == w) begin
            drop_shadow_entry(i);
            r.status = STAT_OK;
          end
      end
      MODE_REMOVE_ALL: begin
        kept = 0;
        for (i = 0; i < shadow_len; i++)
          if (shadow_mem[i] != w) begin
            shadow_mem[kept] = shadow_mem[i];
            kept++;
          end
        if (kept == shadow_len) r.status = STAT_MISSING;
        shadow_len = kept;
      end
      MODE_READ: begin
        if (p >= shadow_len) r.status = STAT_RANGE;
        else r.read_word = shadow_mem[p];
      end
      default: ;
    endcase
    r.length = shadow_len[4:0];
  endtask

  // drives one request, waits for it to be taken, then maybe leaves a gap
  task automatic send_request(input logic [2:0] m, input logic [4:0] p, input logic [31:0] w,
                              input logic given, input array_reply_t given_reply);
    array_reply_t r;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {w, p, m};
    do @(posedge clk); while (in_tready !== 1'b1);
    apply_to_shadow(m, p, w, r);
    if (given) r = given_reply;
    replies_due = {replies_due, r};
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // receiver stalls follow a rotating pattern that is reloaded now and then
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      pattern_left <= $urandom_range(16, 96);
      ready_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom_range(1, 16'hffff));
    end else begin
      pattern_left <= pattern_left - 1;
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    out_tready <= ready_pattern[0];
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        $display("%0t: result with none pending, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        seen_due = replies_due.pop_front();
        if (out_tdata[1:0] !== seen_due.status) begin
          $display("%0t: status expected %0d actual %0d", $time, seen_due.status,
                   out_tdata[1:0]);
          mismatches++;
        end
        if (out_tdata[6:2] !== seen_due.length) begin
          $display("%0t: length expected %0d actual %0d", $time, seen_due.length,
                   out_tdata[6:2]);
          mismatches++;
        end
        if (out_tdata[38:7] !== seen_due.read_word) begin
          $display("%0t: read_word expected %h actual %h", $time, seen_due.read_word,
                   out_tdata[38:7]);
          mismatches++;
        end
        if (out_tdata[39] !== 1'b0) begin
          $display("%0t: pad bit expected 0 actual %b", $time, out_tdata[39]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    int pick;
    int phase_left;
    bit filling;
    logic [2:0] m;
    logic [4:0] p;
    logic [31:0] w;
    logic [31:0] word_pool [4];
    phase_left = 0;
    filling = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_PLAN[k])
      for (n = 0; n < DIRECTED_PLAN[k].reps; n++)
        send_request(DIRECTED_PLAN[k].mode, DIRECTED_PLAN[k].position, DIRECTED_PLAN[k].word,
                     DIRECTED_PLAN[k].given, DIRECTED_PLAN[k].reply);

    // alternate fill and drain phases; a small word pool makes searches hit
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(30, 120);
        filling = !filling;
        foreach (word_pool[k])
          word_pool[k] = ($urandom_range(0, 3) == 0) ? EXTREME_WORDS[$urandom_range(0, 3)]
                                                     : $urandom();
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 30 : 10)) m = MODE_APPEND;
      else if (pick < (filling ? 55 : 20)) m = MODE_INSERT;
      else if (pick < (filling ? 65 : 45)) m = MODE_REMOVE_IDX;
      else if (pick < (filling ? 75 : 65)) m = MODE_REMOVE_FIRST;
      else if (pick < (filling ? 80 : 75)) m = MODE_REMOVE_ALL;
      else if (pick < 97) m = MODE_READ;
      else m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
      p = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(0, shadow_len))
                                      : 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 9);
      if (pick < 6) w = word_pool[$urandom_range(0, 3)];
      else if (pick < 8) w = EXTREME_WORDS[$urandom_range(0, 3)];
      else w = $urandom();
      send_request(m, p, w, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
